### sv/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared constants, request codes and controller/datapath structs for the
// 3x3 multichannel convolution block.
// ----------------------------------------------------------------------------
package cnv_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_IN_CH  = 4;
   localparam int MAX_OUT_CH = 16;
   localparam int KSIDE      = 3;
   localparam int KTAPS      = KSIDE * KSIDE;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CH_W    = $clog2(MAX_IN_CH);
   localparam int OCH_W   = $clog2(MAX_OUT_CH);
   localparam int SLOT_W  = 2;
   localparam int SADDR_W = SLOT_W + COL_W + CH_W;
   localparam int STORE_DEPTH  = KSIDE * MAX_WIDTH * MAX_IN_CH;
   localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * KTAPS;
   localparam int WADDR_W = 10;

   localparam logic [1:0] FUNC_WEIGHT = 2'd0;
   localparam logic [1:0] FUNC_BIAS   = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_FRAME  = 2'd3;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IN_CHANNELS  = 2'd1;
   localparam logic [1:0] CSR_OUT_CHANNELS = 2'd2;

   typedef struct packed {
      logic             take;
      logic             issue;
      logic             first;
      logic             last;
      logic             last_oc;
      logic [OCH_W-1:0] o;
      logic [CH_W-1:0]  i;
      logic [1:0]       ky;
      logic [1:0]       kx;
   } cnv_cmd_type;

   typedef struct packed {
      logic       trigger;
      logic       pipe_busy;
      logic       fifo_empty;
      logic [2:0] ic;
      logic [4:0] oc;
   } cnv_sts_type;

   typedef struct packed {
      logic [3:0]         channel;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [39:0] value;
      logic               last;
   } cnv_result_type;

endpackage

### sv/cnv_if.sv
// ----------------------------------------------------------------------------
// cnv_req_if / cnv_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cnv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [9:0]         weight_slot;
   logic signed [15:0] weight_value;
   logic [3:0]         bias_channel;
   logic signed [31:0] bias_value;
   logic signed [15:0] sample;
   modport source (output valid, func, weight_slot, weight_value, bias_channel,
                   bias_value, sample, input ready);
   modport sink (input valid, func, weight_slot, weight_value, bias_channel,
                 bias_value, sample, output ready);
endinterface

interface cnv_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         result_channel;
   logic [7:0]         result_row;
   logic [7:0]         result_col;
   logic signed [39:0] result_value;
   logic               last_of_pixel;
   modport source (output valid, result_channel, result_row, result_col,
                   result_value, last_of_pixel, input ready);
   modport sink (input valid, result_channel, result_row, result_col,
                 result_value, last_of_pixel, output ready);
endinterface

### sv/cnv_ctrl.sv
// ----------------------------------------------------------------------------
// cnv_ctrl
// Sequencer: accepts items, then walks output channel, input channel and
// tap counters to drive the shared multiply-accumulate.
// ----------------------------------------------------------------------------
module cnv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_func,
   output logic                 req_ready,
   input  cnv_pkg::cnv_sts_type sts,
   output cnv_pkg::cnv_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WAIT  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [cnv_pkg::OCH_W-1:0]    o_ff, o_in;
   logic [cnv_pkg::CH_W-1:0]     i_ff, i_in;
   logic [1:0]                   ky_ff, ky_in, kx_ff, kx_in;
   logic                         take, i_end, o_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign i_end     = ({1'b0, i_ff} == sts.ic - 3'd1);
   assign o_end     = ({1'b0, o_ff} == sts.oc - 5'd1);

   always_comb begin
      state_in = state_ff;
      o_in     = o_ff;
      i_in     = i_ff;
      ky_in    = ky_ff;
      kx_in    = kx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_func == cnv_pkg::FUNC_SAMPLE && sts.trigger) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // hold until earlier results have drained from the queue
            o_in  = '0;
            i_in  = '0;
            ky_in = '0;
            kx_in = '0;
            if (sts.fifo_empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (kx_ff == 2'd2) begin
               kx_in = '0;
               if (ky_ff == 2'd2) begin
                  ky_in = '0;
                  if (i_end) begin
                     i_in = '0;
                     if (o_end) begin
                        state_in = ST_DRAIN;
                     end else begin
                        o_in = o_ff + 1'b1;
                     end
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  ky_in = ky_ff + 2'd1;
               end
            end else begin
               kx_in = kx_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         o_ff     <= '0;
         i_ff     <= '0;
         ky_ff    <= '0;
         kx_ff    <= '0;
      end else begin
         state_ff <= state_in;
         o_ff     <= o_in;
         i_ff     <= i_in;
         ky_ff    <= ky_in;
         kx_ff    <= kx_in;
      end
   end

   always_comb begin
      cmd.take    = take;
      cmd.issue   = (state_ff == ST_RUN);
      cmd.first   = (i_ff == '0) && (ky_ff == 2'd0) && (kx_ff == 2'd0);
      cmd.last    = i_end && (ky_ff == 2'd2) && (kx_ff == 2'd2);
      cmd.last_oc = o_end;
      cmd.o       = o_ff;
      cmd.i       = i_ff;
      cmd.ky      = ky_ff;
      cmd.kx      = kx_ff;
   end

endmodule

### sv/cnv_dp.sv
// ----------------------------------------------------------------------------
// cnv_dp
// Datapath: settings, position counters, line store, weight and bias
// tables, pipelined multiply-accumulate and the result queue.
// ----------------------------------------------------------------------------
module cnv_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [8:0]            csr_wdata,
   input  cnv_pkg::cnv_cmd_type  cmd,
   input  logic [1:0]            req_func,
   input  logic [9:0]            req_weight_slot,
   input  logic signed [15:0]    req_weight_value,
   input  logic [3:0]            req_bias_channel,
   input  logic signed [31:0]    req_bias_value,
   input  logic signed [15:0]    req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cnv_pkg::cnv_result_type rsp_data,
   output cnv_pkg::cnv_sts_type  sts
);

   localparam int QDEPTH = cnv_pkg::MAX_OUT_CH;
   localparam int QPTR_W = $clog2(QDEPTH);

   logic [8:0] width_ff;
   logic [2:0] inch_ff;
   logic [4:0] outch_ff;
   logic [8:0] w_lim;
   logic [2:0] ic_lim;
   logic [4:0] oc_lim;

   logic [cnv_pkg::COL_W-1:0]  row_ff, col_ff, tgt_row_ff, tgt_col_ff;
   logic [cnv_pkg::CH_W-1:0]   ch_ff;
   logic [cnv_pkg::SLOT_W-1:0] slot_ff, tgt_slot_ff;
   logic                       px_last, take_sample;

   logic signed [15:0] store_mem  [cnv_pkg::STORE_DEPTH];
   logic signed [15:0] weight_mem [cnv_pkg::WEIGHT_DEPTH];
   logic signed [31:0] bias_mem   [cnv_pkg::MAX_OUT_CH];

   logic [2:0]                  slot_sum;
   logic [cnv_pkg::SLOT_W-1:0]  rd_slot;
   logic [cnv_pkg::COL_W-1:0]   rd_col;
   logic [cnv_pkg::SADDR_W-1:0] rd_addr, wr_addr;
   logic [6:0]                  oi;
   logic [cnv_pkg::WADDR_W-1:0] waddr;

   logic                      s1_vld_ff, s2_vld_ff;
   logic                      s1_first_ff, s1_last_ff, s1_loc_ff;
   logic                      s2_first_ff, s2_last_ff, s2_loc_ff;
   logic [cnv_pkg::OCH_W-1:0] s1_o_ff, s2_o_ff;
   logic signed [15:0]        s1_sample_ff, s1_weight_ff;
   logic signed [31:0]        s1_bias_ff, s2_bias_ff, s2_prod_ff;
   logic signed [39:0]        acc_ff, acc_in;

   cnv_pkg::cnv_result_type q_mem [QDEPTH];
   logic [QPTR_W-1:0]       q_wr_ff, q_rd_ff;
   logic [QPTR_W:0]         q_cnt_ff;
   logic                    q_push, q_pop;

   // settings, saturated to their legal ranges
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'(cnv_pkg::MAX_WIDTH);
         inch_ff  <= 3'd1;
         outch_ff <= 5'(cnv_pkg::MAX_OUT_CH);
      end else if (csr_we) begin
         unique case (csr_index)
            cnv_pkg::CSR_IMAGE_WIDTH:  width_ff <= csr_wdata;
            cnv_pkg::CSR_IN_CHANNELS:  inch_ff  <= csr_wdata[2:0];
            cnv_pkg::CSR_OUT_CHANNELS: outch_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign w_lim  = (width_ff < 9'd3) ? 9'd3 :
                   (width_ff > 9'(cnv_pkg::MAX_WIDTH)) ? 9'(cnv_pkg::MAX_WIDTH) : width_ff;
   assign ic_lim = (inch_ff == 3'd0) ? 3'd1 :
                   (inch_ff > 3'(cnv_pkg::MAX_IN_CH)) ? 3'(cnv_pkg::MAX_IN_CH) : inch_ff;
   assign oc_lim = (outch_ff == 5'd0) ? 5'd1 :
                   (outch_ff > 5'(cnv_pkg::MAX_OUT_CH)) ? 5'(cnv_pkg::MAX_OUT_CH) : outch_ff;

   // raster position
   assign take_sample = cmd.take && (req_func == cnv_pkg::FUNC_SAMPLE);
   assign px_last     = ({1'b0, ch_ff} + 3'd1) >= ic_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
         slot_ff <= '0;
      end else if (cmd.take && req_func == cnv_pkg::FUNC_FRAME) begin
         row_ff  <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
         slot_ff <= '0;
      end else if (take_sample) begin
         if (px_last) begin
            ch_ff <= '0;
            if (({1'b0, col_ff} + 9'd1) >= w_lim) begin
               col_ff <= '0;
               if (({1'b0, row_ff} + 9'd1) >= w_lim) begin
                  row_ff  <= '0;
                  slot_ff <= '0;
               end else begin
                  row_ff  <= row_ff + 1'b1;
                  slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end else begin
            ch_ff <= ch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         tgt_row_ff  <= row_ff;
         tgt_col_ff  <= col_ff;
         tgt_slot_ff <= slot_ff;
      end
   end

   // line store: slot = row mod 3
   assign wr_addr  = {slot_ff, col_ff, ch_ff};
   // row r-2+ky sits in slot (slot(r)+1+ky) mod 3
   assign slot_sum = {1'b0, tgt_slot_ff} + 3'd1 + {1'b0, cmd.ky};
   assign rd_slot  = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
   assign rd_col   = tgt_col_ff - 8'd2 + {6'd0, cmd.kx};
   assign rd_addr  = {rd_slot, rd_col, cmd.i};
   assign oi       = 7'(cmd.o * ic_lim) + {5'd0, cmd.i};
   assign waddr    = ({3'd0, oi} << 3) + {3'd0, oi} + {8'd0, cmd.ky} * 10'd3
                     + {8'd0, cmd.kx};

   always_ff @(posedge clock) begin
      if (take_sample) begin
         store_mem[wr_addr] <= req_sample;
      end
      if (cmd.issue) begin
         s1_sample_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_func == cnv_pkg::FUNC_WEIGHT
          && req_weight_slot < 10'(cnv_pkg::WEIGHT_DEPTH)) begin
         weight_mem[req_weight_slot] <= req_weight_value;
      end
      if (cmd.issue) begin
         s1_weight_ff <= weight_mem[waddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_func == cnv_pkg::FUNC_BIAS) begin
         bias_mem[req_bias_channel] <= req_bias_value;
      end
      if (cmd.issue) begin
         s1_bias_ff <= bias_mem[cmd.o];
      end
   end

   // multiply, then accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last;
      s1_loc_ff   <= cmd.last_oc;
      s1_o_ff     <= cmd.o;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_loc_ff   <= s1_loc_ff;
      s2_o_ff     <= s1_o_ff;
      s2_bias_ff  <= s1_bias_ff;
      s2_prod_ff  <= s1_sample_ff * s1_weight_ff;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_in = (s2_first_ff ? 40'(s2_bias_ff) : acc_ff) + 40'(s2_prod_ff);

   // result queue, deep enough for every output channel of one position
   assign q_push = s2_vld_ff && s2_last_ff;
   assign q_pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_wr_ff].channel <= s2_o_ff;
         q_mem[q_wr_ff].row     <= tgt_row_ff - 8'd2;
         q_mem[q_wr_ff].col     <= tgt_col_ff - 8'd2;
         q_mem[q_wr_ff].value   <= acc_in;
         q_mem[q_wr_ff].last    <= s2_loc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + 1'b1;
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + (QPTR_W+1)'(q_push) - (QPTR_W+1)'(q_pop);
      end
   end

   assign rsp_valid = (q_cnt_ff != '0);
   assign rsp_data  = q_mem[q_rd_ff];

   always_comb begin
      sts.trigger    = px_last && (row_ff >= 8'd2) && (col_ff >= 8'd2);
      sts.pipe_busy  = s1_vld_ff || s2_vld_ff;
      sts.fifo_empty = (q_cnt_ff == '0);
      sts.ic         = ic_lim;
      sts.oc         = oc_lim;
   end

endmodule

### sv/conv3x3_multichannel_bias_top.sv
// ----------------------------------------------------------------------------
// conv3x3_multichannel_bias_top
// Streaming 3x3 valid convolution with bias over a multichannel image.
// ----------------------------------------------------------------------------
// Loads, frame starts and samples that finish no output position are taken
// at once. A sample that completes a position waits until earlier results
// have left the queue, issues out_channels*in_channels*9 products on the single
// multiply-accumulate, then drains the pipeline before taking the next item.
// Results queue up (16 deep) and drain while later items are accepted.
// Reset (synchronous): counters and queue clear; tables are undefined.
module conv3x3_multichannel_bias_top (
   input logic        clock,
   input logic        reset,
   cnv_req_if.sink    req_ch,
   cnv_rsp_if.source  rsp_ch,
   input logic        csr_we,
   input logic [1:0]  csr_index,
   input logic [8:0]  csr_wdata
);

   cnv_pkg::cnv_cmd_type    cmd;
   cnv_pkg::cnv_sts_type    sts;
   cnv_pkg::cnv_result_type res;

   cnv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cnv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .req_func         (req_ch.func),
      .req_weight_slot  (req_ch.weight_slot),
      .req_weight_value (req_ch.weight_value),
      .req_bias_channel (req_ch.bias_channel),
      .req_bias_value   (req_ch.bias_value),
      .req_sample       (req_ch.sample),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_data         (res),
      .sts              (sts)
   );

   assign rsp_ch.result_channel = res.channel;
   assign rsp_ch.result_row     = res.row;
   assign rsp_ch.result_col     = res.col;
   assign rsp_ch.result_value   = res.value;
   assign rsp_ch.last_of_pixel  = res.last;

   // no item is taken while products are being issued
   a_issue_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ch.ready)
      else $error("item accepted during accumulation");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result pending after reset");

   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last_of_pixel |->
         ({1'b0, rsp_ch.result_channel} == sts.oc - 5'd1))
      else $error("last_of_pixel on wrong channel");

endmodule

### tb/conv3x3_multichannel_bias_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_multichannel_bias_top_test
// Streams weight, bias, frame-start and sample items into the 3x3 convolution
// block with bursty sending and a stalling receiver, predicts every result
// from a software copy of the tables and position counters, and checks each
// result field by field in order.
// ----------------------------------------------------------------------------
module conv3x3_multichannel_bias_top_test;

   typedef struct {
      logic [3:0]         channel;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [39:0] value;
      logic               last;
   } conv_out_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [8:0] csr_wdata;

   cnv_req_if req_ch();
   cnv_rsp_if rsp_ch();

   conv3x3_multichannel_bias_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the block
   logic signed [15:0] pixel_mem [0:cnv_pkg::STORE_DEPTH-1];
   logic signed [15:0] coef_mem  [0:cnv_pkg::WEIGHT_DEPTH-1];
   logic signed [31:0] bias_mem  [0:cnv_pkg::MAX_OUT_CH-1];
   int unsigned        cur_row, cur_col, cur_ch;
   logic [8:0]         reg_width;
   logic [2:0]         reg_in_ch;
   logic [4:0]         reg_out_ch;

   conv_out_type pending_outs[$];
   int           error_count;
   int           burst_left;
   int           random_items;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #200ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned pix_addr(int unsigned r, int unsigned c, int unsigned ch);
      return (((r % cnv_pkg::KSIDE) * cnv_pkg::MAX_WIDTH + (c % cnv_pkg::MAX_WIDTH))
              * cnv_pkg::MAX_IN_CH) + (ch % cnv_pkg::MAX_IN_CH);
   endfunction

   // apply one accepted item to the shadow state, queue the results it causes
   task automatic predict_item(input logic [1:0] func, input logic [9:0] slot,
                               input logic signed [15:0] wval, input logic [3:0] bch,
                               input logic signed [31:0] bval,
                               input logic signed [15:0] smp);
      int unsigned  w, ic, oc, r, c, ch, widx;
      logic         last;
      longint       acc;
      conv_out_type res;
      w  = clamp(reg_width, 3, cnv_pkg::MAX_WIDTH);
      ic = clamp(reg_in_ch, 1, cnv_pkg::MAX_IN_CH);
      oc = clamp(reg_out_ch, 1, cnv_pkg::MAX_OUT_CH);
      case (func)
         cnv_pkg::FUNC_WEIGHT: begin
            if (slot < cnv_pkg::WEIGHT_DEPTH) coef_mem[slot] = wval;
         end
         cnv_pkg::FUNC_BIAS: begin
            bias_mem[bch] = bval;
         end
         cnv_pkg::FUNC_FRAME: begin
            cur_row = 0;
            cur_col = 0;
            cur_ch  = 0;
         end
         default: begin
            r  = cur_row;
            c  = cur_col;
            ch = cur_ch;
            pixel_mem[pix_addr(r, c, ch)] = smp;
            last = (ch + 1 >= ic);
            if (last && r >= 2 && c >= 2) begin
               for (int o = 0; o < oc; o++) begin
                  acc = longint'(bias_mem[o]);
                  for (int i = 0; i < ic; i++)
                     for (int ky = 0; ky < cnv_pkg::KSIDE; ky++)
                        for (int kx = 0; kx < cnv_pkg::KSIDE; kx++) begin
                           widx = (o * ic + i) * cnv_pkg::KTAPS + ky * cnv_pkg::KSIDE + kx;
                           if (widx < cnv_pkg::WEIGHT_DEPTH)
                              acc += longint'(pixel_mem[pix_addr(r - 2 + ky, c - 2 + kx, i)])
                                     * longint'(coef_mem[widx]);
                        end
                  res.channel = o[3:0];
                  res.row     = 8'(r - 2);
                  res.col     = 8'(c - 2);
                  res.value   = acc[39:0];
                  res.last    = (o + 1 == oc);
                  pending_outs.push_back(res);
               end
            end
            if (last) begin
               cur_ch = 0;
               if (c + 1 >= w) begin
                  cur_col = 0;
                  cur_row = (r + 1 >= w) ? 0 : r + 1;
               end else begin
                  cur_col = c + 1;
               end
            end else begin
               cur_ch = ch + 1;
            end
         end
      endcase
   endtask

   // send one item in bursts with random gaps; returns at the accepting edge
   task automatic send_item(input logic [1:0] func, input logic [9:0] slot,
                            input logic signed [15:0] wval, input logic [3:0] bch,
                            input logic signed [31:0] bval, input logic signed [15:0] smp);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.weight_slot  <= slot;
      req_ch.weight_value <= wval;
      req_ch.bias_channel <= bch;
      req_ch.bias_value   <= bval;
      req_ch.sample       <= smp;
      do @(posedge clock); while (!req_ch.ready);
      predict_item(func, slot, wval, bch, bval, smp);
      burst_left--;
   endtask

   task automatic send_weight(input logic [9:0] slot, input logic signed [15:0] wval);
      send_item(cnv_pkg::FUNC_WEIGHT, slot, wval, 4'($urandom), $urandom, 16'($urandom));
   endtask

   task automatic send_bias(input logic [3:0] bch, input logic signed [31:0] bval);
      send_item(cnv_pkg::FUNC_BIAS, 10'($urandom), 16'($urandom), bch, bval, 16'($urandom));
   endtask

   task automatic send_sample(input logic signed [15:0] smp);
      send_item(cnv_pkg::FUNC_SAMPLE, 10'($urandom), 16'($urandom), 4'($urandom), $urandom,
                smp);
   endtask

   task automatic send_frame();
      send_item(cnv_pkg::FUNC_FRAME, 10'($urandom), 16'($urandom), 4'($urandom), $urandom,
                16'($urandom));
   endtask

   // wait for every result, then let trailing work settle
   task automatic drain_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         cnv_pkg::CSR_IMAGE_WIDTH:  reg_width  = data;
         cnv_pkg::CSR_IN_CHANNELS:  reg_in_ch  = data[2:0];
         cnv_pkg::CSR_OUT_CHANNELS: reg_out_ch = data[4:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(input logic [8:0] w, input logic [8:0] ic, input logic [8:0] oc);
      write_csr(cnv_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(cnv_pkg::CSR_IN_CHANNELS, ic);
      write_csr(cnv_pkg::CSR_OUT_CHANNELS, oc);
   endtask

   task automatic send_frame_of(input int unsigned n, input logic signed [15:0] fixed_val,
                                input bit use_fixed);
      send_frame();
      for (int k = 0; k < n; k++)
         send_sample(use_fixed ? fixed_val : 16'($urandom));
   endtask

   function automatic int unsigned frame_len();
      int unsigned w;
      w = clamp(reg_width, 3, cnv_pkg::MAX_WIDTH);
      return w * w * clamp(reg_in_ch, 1, cnv_pkg::MAX_IN_CH);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      conv_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outs.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.result_value, 0);
         end else begin
            want = pending_outs.pop_front();
            if (rsp_ch.result_channel !== want.channel)
               report_mismatch("result_channel", rsp_ch.result_channel, want.channel);
            if (rsp_ch.result_row !== want.row)
               report_mismatch("result_row", rsp_ch.result_row, want.row);
            if (rsp_ch.result_col !== want.col)
               report_mismatch("result_col", rsp_ch.result_col, want.col);
            if (rsp_ch.result_value !== want.value)
               report_mismatch("result_value", rsp_ch.result_value, want.value);
            if (rsp_ch.last_of_pixel !== want.last)
               report_mismatch("last_of_pixel", rsp_ch.last_of_pixel, want.last);
         end
      end
   end

   // receiver: switch between free flow, random stalls and long stalls
   int rsp_mode, rsp_mode_left, rsp_hold;
   always @(negedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      = $urandom_range(0, 2);
         rsp_mode_left = $urandom_range(20, 200);
      end
      rsp_mode_left--;
      case (rsp_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (rsp_hold > 0) begin
               rsp_hold--;
               rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
               rsp_hold = $urandom_range(5, 25);
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic test_table_fill();
      for (int s = 0; s < cnv_pkg::WEIGHT_DEPTH; s++) send_weight(s[9:0], 16'($urandom));
      for (int b = 0; b < cnv_pkg::MAX_OUT_CH; b++) send_bias(b[3:0], $urandom);
      drain_idle();
   endtask

   task automatic test_directed_extremes();
      set_shape(9'd3, 9'd1, 9'd2);
      for (int t = 0; t < cnv_pkg::KTAPS; t++) send_weight(t[9:0], 16'sh8000);
      for (int t = 0; t < cnv_pkg::KTAPS; t++) send_weight(10'(cnv_pkg::KTAPS + t), 16'sh7fff);
      send_weight(10'd1023, 16'sh1234);                  // beyond table: ignored
      send_weight(10'(cnv_pkg::WEIGHT_DEPTH), 16'sh4321); // first slot past the end
      send_bias(4'd0, 32'sh7fffffff);
      send_bias(4'd1, 32'sh80000000);
      send_frame_of(9, 16'sh8000, 1'b1);
      send_frame_of(9, 16'sh7fff, 1'b1);
      // wrap at end of frame without a frame start
      for (int k = 0; k < 9; k++) send_sample(16'sh8000);
      send_frame_of(9, 16'sh0000, 1'b1);
      drain_idle();
   endtask

   task automatic test_register_saturation();
      set_shape(9'd0, 9'd0, 9'd0);      // floor to 3, 1, 1
      send_frame_of(frame_len(), 0, 1'b0);
      drain_idle();
      set_shape(9'd2, 9'd7, 9'd31);     // 3 wide, 4 in, 16 out
      send_frame_of(frame_len(), 0, 1'b0);
      drain_idle();
      set_shape(9'd4, 9'd5, 9'd17);
      send_frame_of(frame_len(), 0, 1'b0);
      drain_idle();
   endtask

   task automatic test_widest_image();
      set_shape(9'd511, 9'd1, 9'd1);    // saturates to the full width
      send_frame_of(2 * cnv_pkg::MAX_WIDTH + 12, 0, 1'b0);
      drain_idle();
      set_shape(9'd256, 9'd1, 9'd1);
      send_frame_of(2 * cnv_pkg::MAX_WIDTH + 4, 0, 1'b0);
      drain_idle();
   endtask

   task automatic test_random_frames();
      int unsigned n, pick;
      while (random_items < 220) begin
         set_shape(9'($urandom_range(3, 6)), 9'($urandom_range(1, 4)),
                   ($urandom_range(0, 4) == 0) ? 9'd16 : 9'($urandom_range(1, 4)));
         n = frame_len() * $urandom_range(1, 2);
         send_frame();
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 49);
            if (pick < 2)
               send_weight(10'($urandom), 16'($urandom));
            else if (pick < 3)
               send_bias(4'($urandom), $urandom);
            else if (pick < 4)
               send_frame();            // break the frame
            else if (pick < 6)
               send_sample(($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff);
            else
               send_sample(16'($urandom));
            random_items++;
         end
         drain_idle();
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = cnv_pkg::CSR_IMAGE_WIDTH;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.func         = cnv_pkg::FUNC_FRAME;
      req_ch.weight_slot  = '0;
      req_ch.weight_value = '0;
      req_ch.bias_channel = '0;
      req_ch.bias_value   = '0;
      req_ch.sample       = '0;
      rsp_ch.ready        = 1'b0;
      rsp_mode            = 0;
      rsp_mode_left       = 0;
      rsp_hold            = 0;
      reg_width           = 9'd256;
      reg_in_ch           = 3'd1;
      reg_out_ch          = 5'd16;
      cur_row             = 0;
      cur_col             = 0;
      cur_ch              = 0;
      error_count         = 0;
      burst_left          = 0;
      random_items        = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(posedge clock);

      test_table_fill();
      test_directed_extremes();
      test_register_saturation();
      test_widest_image();
      test_random_frames();

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

### sim.f
sv/cnv_pkg.sv
sv/cnv_if.sv
sv/cnv_ctrl.sv
sv/cnv_dp.sv
sv/conv3x3_multichannel_bias_top.sv
tb/conv3x3_multichannel_bias_top_test.sv
